// ===== rtl/bfcdm_pkg.sv =====
package bfcdm_pkg;

  localparam int MAX_QUBITS = 4;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int TGT_W    = 2;
  localparam int PROB_W   = 17;
  localparam int QCFG_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = PROB_W;

  localparam int IDX_W  = MAX_QUBITS;
  localparam int ADDR_W = 2 * MAX_QUBITS;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int NQ_W   = ($clog2(MAX_QUBITS + 1) > QCFG_W) ? $clog2(MAX_QUBITS + 1) : QCFG_W;
  localparam int CMP_W  = ((POS_W > MAX_QUBITS) ? POS_W : MAX_QUBITS) + 1;

  localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);
  localparam logic [QCFG_W-1:0] QUBITS_RST = QCFG_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_APPLY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLIP_PROB = 1'b0,
    REG_QUBITS    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RD,
    S_MA,
    S_WA,
    S_WB
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } word_t;

endpackage

// ===== rtl/bfcdm_in_if.sv =====
interface bfcdm_in_if;
  import bfcdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        row;
  logic [POS_W-1:0]        col;
  logic signed [VAL_W-1:0] value_re;
  logic signed [VAL_W-1:0] value_im;
  logic [TGT_W-1:0]        tgt_qubit;

  modport source (output valid, command, row, col, value_re, value_im, tgt_qubit,
                  input ready);
  modport sink (input valid, command, row, col, value_re, value_im, tgt_qubit,
                output ready);
endinterface

// ===== rtl/bfcdm_out_if.sv =====
interface bfcdm_out_if;
  import bfcdm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_re;
  logic signed [VAL_W-1:0] result_im;

  modport source (output valid, result_re, result_im, input ready);
  modport sink (input valid, result_re, result_im, output ready);
endinterface

// ===== rtl/bfcdm_cfg_if.sv =====
interface bfcdm_cfg_if;
  import bfcdm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bit_flip_channel_density_matrix.sv =====
// Density matrix store with an in-place bit-flip channel. Each request gets
// exactly one response: a read returns the element (zero when row or col is
// outside the active dimension), write and apply return zero. A write is
// answered from idle; a read goes through the registered memory read and the
// S_READ state before its response. An apply walks the element pairs
// (i, j) / (i^m, j^m) of the dim x dim active block one at a time, each in four
// steps (read both entries, multiply for the first, write the first while
// multiplying for the second, write the second), and responds after the last
// pair, with dim = 2^qubits_in_use; an apply on a target outside the qubit
// count responds at once. The pace is set by the single write port of the
// element memory. Reads of never-written elements return undefined data.
module bit_flip_channel_density_matrix (
  input  logic clk,
  input  logic rst_n,
  bfcdm_in_if.sink    in_ch,
  bfcdm_out_if.source out_ch,
  bfcdm_cfg_if.sink   cfg_ch
);
  import bfcdm_pkg::*;

  // configuration
  logic [PROB_W-1:0] flip_prob_r;
  logic [QCFG_W-1:0] qubits_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_prob_r <= '0;
      qubits_r    <= QUBITS_RST;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_FLIP_PROB: flip_prob_r <= cfg_ch.data[PROB_W-1:0];
        REG_QUBITS:    qubits_r    <= cfg_ch.data[QCFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PROB_W-1:0] p_eff, q_eff;
  logic [NQ_W-1:0]   nq_raw, nq;
  logic [CMP_W-1:0]  dim;

  assign p_eff  = (flip_prob_r > ONE_Q16) ? ONE_Q16 : flip_prob_r;
  assign q_eff  = ONE_Q16 - p_eff;
  assign nq_raw = NQ_W'(qubits_r);
  assign nq     = (nq_raw == '0) ? NQ_W'(1) :
                  (nq_raw > NQ_W'(MAX_QUBITS)) ? NQ_W'(MAX_QUBITS) : nq_raw;
  assign dim    = CMP_W'(1) << nq;

  // request decode
  logic              in_acc;
  logic              in_inside;
  logic              tgt_ok;
  logic [ADDR_W-1:0] in_addr;
  cmd_t              in_cmd;

  assign in_acc    = in_ch.valid & in_ch.ready;
  assign in_cmd    = cmd_t'(in_ch.command);
  assign in_inside = (CMP_W'(in_ch.row) < dim) && (CMP_W'(in_ch.col) < dim);
  assign tgt_ok    = NQ_W'(in_ch.tgt_qubit) < nq;
  assign in_addr   = {IDX_W'(in_ch.row), IDX_W'(in_ch.col)};

  // sequencer state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic             rd_ok_r, rd_ok_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_re_r, out_re_nxt;
  logic signed [VAL_W-1:0] out_im_r, out_im_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  word_t             mem_wdata;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_raddr_a;
  logic [ADDR_W-1:0] addr_a, addr_b;
  word_t             rdata_a, rdata_b;

  logic  mix_load;
  word_t mix_keep, mix_flip, mix_out;

  logic [CMP_W-1:0] col_inc, row_inc;

  assign addr_a = {row_r, col_r};
  assign addr_b = {row_r ^ m_r, col_r ^ m_r};

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    m_nxt         = m_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_a;
    mem_wdata     = mix_out;
    mem_rd_en     = 1'b0;
    mem_raddr_a   = addr_a;
    mix_load      = 1'b0;
    mix_keep      = rdata_a;
    mix_flip      = rdata_b;
    col_inc       = CMP_W'(col_r) + CMP_W'(1);
    row_inc       = CMP_W'(row_r) + CMP_W'(1);
    if ((row_inc & CMP_W'(m_r)) != '0) begin
      row_inc = row_inc + CMP_W'(m_r);
    end

    unique case (state_r)
      S_IDLE: begin
        mem_raddr_a = in_addr;
        if (in_acc) begin
          out_re_nxt = '0;
          out_im_nxt = '0;
          case (in_cmd)
            CMD_WRITE: begin
              mem_we        = in_inside;
              mem_waddr     = in_addr;
              mem_wdata.re  = in_ch.value_re;
              mem_wdata.im  = in_ch.value_im;
              out_valid_nxt = 1'b1;
            end
            CMD_READ: begin
              mem_rd_en = 1'b1;
              rd_ok_nxt = in_inside;
              state_nxt = S_READ;
            end
            CMD_APPLY: begin
              if (tgt_ok) begin
                row_nxt   = '0;
                col_nxt   = '0;
                m_nxt     = IDX_W'(1) << in_ch.tgt_qubit;
                state_nxt = S_RD;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_re_nxt    = rd_ok_r ? rdata_a.re : '0;
        out_im_nxt    = rd_ok_r ? rdata_a.im : '0;
        state_nxt     = S_IDLE;
      end
      S_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_MA;
      end
      S_MA: begin
        mix_load  = 1'b1;
        state_nxt = S_WA;
      end
      S_WA: begin
        // write the first entry while the second entry's products load
        mem_we    = 1'b1;
        mem_waddr = addr_a;
        mix_load  = 1'b1;
        mix_keep  = rdata_b;
        mix_flip  = rdata_a;
        state_nxt = S_WB;
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b;
        state_nxt = S_RD;
        if (col_inc == dim) begin
          col_nxt = '0;
          row_nxt = IDX_W'(row_inc);
          if (row_inc >= dim) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_re_nxt    = '0;
            out_im_nxt    = '0;
          end
        end else begin
          col_nxt = IDX_W'(col_inc);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    m_r      <= m_nxt;
    rd_ok_r  <= rd_ok_nxt;
    out_re_r <= out_re_nxt;
    out_im_r <= out_im_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_re = out_re_r;
  assign out_ch.result_im = out_im_r;

  bfcdm_store u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .rd_en   (mem_rd_en),
    .raddr_a (mem_raddr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bfcdm_mix u_mix (
    .clk    (clk),
    .load   (mix_load),
    .keep   (mix_keep),
    .flip   (mix_flip),
    .q      (q_eff),
    .p      (p_eff),
    .result (mix_out)
  );

  // no memory write while a read response is pending
  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !mem_we)
    else $error("memory written during read");

  // a new response only follows an accepted request, a read or a finished apply
  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(in_acc) || $past(state_r == S_READ) ||
                            $past(state_r == S_WB)))
    else $error("response without a cause");

  // the second write of a pair goes to the partner entry, right after the first
  a_pair_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (mem_we && (mem_waddr == addr_b) && $past(state_r == S_WA)))
    else $error("pair write out of order");

endmodule

// ===== rtl/bfcdm_store.sv =====
module bfcdm_store (
  input  logic                         clk,
  input  logic                         we,
  input  logic [bfcdm_pkg::ADDR_W-1:0] waddr,
  input  bfcdm_pkg::word_t             wdata,
  input  logic                         rd_en,
  input  logic [bfcdm_pkg::ADDR_W-1:0] raddr_a,
  input  logic [bfcdm_pkg::ADDR_W-1:0] raddr_b,
  output bfcdm_pkg::word_t             rdata_a,
  output bfcdm_pkg::word_t             rdata_b
);
  import bfcdm_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_a_r;
  word_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/bfcdm_mix.sv =====
module bfcdm_mix (
  input  logic                         clk,
  input  logic                         load,
  input  bfcdm_pkg::word_t             keep,
  input  bfcdm_pkg::word_t             flip,
  input  logic [bfcdm_pkg::PROB_W-1:0] q,
  input  logic [bfcdm_pkg::PROB_W-1:0] p,
  output bfcdm_pkg::word_t             result
);
  import bfcdm_pkg::*;

  localparam int PROD_W = VAL_W + PROB_W + 1;
  localparam int TERM_W = PROD_W - 16;
  localparam int SUM_W  = TERM_W + 1;

  logic signed [PROD_W-1:0] keep_re_r, flip_re_r, keep_im_r, flip_im_r;

  always_ff @(posedge clk) begin
    if (load) begin
      keep_re_r <= $signed(PROD_W'(keep.re)) * $signed(PROD_W'({1'b0, q}));
      flip_re_r <= $signed(PROD_W'(flip.re)) * $signed(PROD_W'({1'b0, p}));
      keep_im_r <= $signed(PROD_W'(keep.im)) * $signed(PROD_W'({1'b0, q}));
      flip_im_r <= $signed(PROD_W'(flip.im)) * $signed(PROD_W'({1'b0, p}));
    end
  end

  // dropping the low 16 bits floors each term
  function automatic logic signed [VAL_W-1:0] sat_sum(
    input logic signed [PROD_W-1:0] a,
    input logic signed [PROD_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'($signed(a[PROD_W-1:16])) + SUM_W'($signed(b[PROD_W-1:16]));
    if (s > SUM_W'($signed({1'b0, {(VAL_W-1){1'b1}}}))) begin
      sat_sum = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (s < SUM_W'($signed({1'b1, {(VAL_W-1){1'b0}}}))) begin
      sat_sum = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_sum = s[VAL_W-1:0];
    end
  endfunction

  assign result.re = sat_sum(keep_re_r, flip_re_r);
  assign result.im = sat_sum(keep_im_r, flip_im_r);

endmodule
